[hdl/ncse_pkg.sv]
// shared types and constants of the null-carrier snr estimator
`default_nettype none

package ncse_pkg;

    localparam int MAX_VECTOR_LENGTH  = 1024;
    localparam int MAX_FRAME_MULTIPLE = 16;

    localparam int VL_W     = 11;
    localparam int FM_W     = 5;
    localparam int POS_W    = 14;
    localparam int FLEN_W   = 15;
    localparam int SQ_W     = 31;
    localparam int MAG_W    = 32;
    localparam int LOADED_W = 43;
    localparam int NULL_W   = 42;
    localparam int SNR_W    = 32;
    localparam int NOISE_W  = 32;
    localparam int FRAC_SHIFT = 15;
    localparam int SAT_SHIFT  = 16;
    localparam int DVD_W      = LOADED_W + FRAC_SHIFT;
    localparam int DIV_STEPS  = NULL_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MULTIPLE = 1'b1;

    localparam logic [VL_W-1:0] VL_RESET = 11'd64;
    localparam logic [FM_W-1:0] FM_RESET = 5'd4;

    localparam logic signed [SNR_W-1:0] SNR_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0] sample_i;
        logic signed [15:0] sample_q;
    } sample_t;

    typedef struct packed {
        logic signed [SNR_W-1:0] snr_estimate;
        logic [NOISE_W-1:0]      noise_power;
        logic                    null_power_zero;
    } result_t;

    // finished frame sums handed from the front to the back
    typedef struct packed {
        logic [LOADED_W-1:0] loaded_sum;
        logic [NULL_W-1:0]   null_sum;
        logic [VL_W-1:0]     vector_length;
    } frame_sums_t;

endpackage

`default_nettype wire

[hdl/ncse_front.sv]
// front end: configuration, frame position, power squaring and window accumulation
`default_nettype none

module ncse_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [ncse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ncse_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire ncse_pkg::sample_t                   sample,
    input  wire logic [1:0]                          queue_level,
    output logic                                     push,
    output ncse_pkg::frame_sums_t                    push_data
);

    logic [ncse_pkg::VL_W-1:0]     vector_length_reg;
    logic [ncse_pkg::FM_W-1:0]     frame_multiple_reg;
    logic [ncse_pkg::POS_W-1:0]    pos_reg, pos_next;

    // squaring stage
    logic                          a_valid_reg;
    logic [ncse_pkg::SQ_W-1:0]     a_sq_i_reg, a_sq_q_reg;
    logic                          a_loaded_reg, a_null_reg, a_last_reg;
    logic [ncse_pkg::VL_W-1:0]     a_vl_reg;

    // accumulators
    logic [ncse_pkg::LOADED_W-1:0] loaded_reg, loaded_next;
    logic [ncse_pkg::NULL_W-1:0]   null_reg, null_next;

    logic [ncse_pkg::VL_W-1:0]     vl_eff;
    logic [ncse_pkg::FM_W-1:0]     fm_eff;
    logic [ncse_pkg::FLEN_W-1:0]   flen, pos_ext, pos_inc, two_vl, three_vl;
    logic                          accept, is_last, in_loaded, in_null;
    logic signed [31:0]            prod_i, prod_q;
    logic [ncse_pkg::MAG_W-1:0]    mag;

    // out-of-range register values are clamped
    always_comb
    begin
        if (vector_length_reg == '0)
            vl_eff = ncse_pkg::VL_W'(1);
        else if (vector_length_reg > ncse_pkg::VL_W'(ncse_pkg::MAX_VECTOR_LENGTH))
            vl_eff = ncse_pkg::VL_W'(ncse_pkg::MAX_VECTOR_LENGTH);
        else
            vl_eff = vector_length_reg;

        if (frame_multiple_reg < ncse_pkg::FM_W'(3))
            fm_eff = ncse_pkg::FM_W'(3);
        else if (frame_multiple_reg > ncse_pkg::FM_W'(ncse_pkg::MAX_FRAME_MULTIPLE))
            fm_eff = ncse_pkg::FM_W'(ncse_pkg::MAX_FRAME_MULTIPLE);
        else
            fm_eff = frame_multiple_reg;
    end

    always_comb
    begin
        flen      = ncse_pkg::FLEN_W'(vl_eff) * ncse_pkg::FLEN_W'(fm_eff);
        pos_ext   = ncse_pkg::FLEN_W'(pos_reg);
        pos_inc   = pos_ext + ncse_pkg::FLEN_W'(1);
        two_vl    = {ncse_pkg::FLEN_W'(vl_eff)} << 1;
        three_vl  = two_vl + ncse_pkg::FLEN_W'(vl_eff);
        is_last   = (pos_inc >= flen);
        in_loaded = (pos_ext < two_vl);
        in_null   = !in_loaded && (pos_ext < three_vl);
        pos_next  = is_last ? '0 : pos_inc[ncse_pkg::POS_W-1:0];
        prod_i    = sample.sample_i * sample.sample_i;
        prod_q    = sample.sample_q * sample.sample_q;
    end

    // a frame end already in the squaring stage needs its own free slot
    assign sample_ready = (queue_level == 2'd0) ||
                          ((queue_level == 2'd1) && !(a_valid_reg && a_last_reg));
    assign accept = sample_valid && sample_ready;

    always_comb
    begin
        mag         = ncse_pkg::MAG_W'(a_sq_i_reg) + ncse_pkg::MAG_W'(a_sq_q_reg);
        loaded_next = loaded_reg;
        null_next   = null_reg;
        if (a_valid_reg && a_loaded_reg)
            loaded_next = loaded_reg + ncse_pkg::LOADED_W'(mag);
        if (a_valid_reg && a_null_reg)
            null_next = null_reg + ncse_pkg::NULL_W'(mag);
        push                    = a_valid_reg && a_last_reg;
        push_data.loaded_sum    = loaded_next;
        push_data.null_sum      = null_next;
        push_data.vector_length = a_vl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg  <= ncse_pkg::VL_RESET;
            frame_multiple_reg <= ncse_pkg::FM_RESET;
            pos_reg            <= '0;
            a_valid_reg        <= 1'b0;
            loaded_reg         <= '0;
            null_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ncse_pkg::CFG_VECTOR_LENGTH:
                        vector_length_reg <= cfg_data[ncse_pkg::VL_W-1:0];
                    ncse_pkg::CFG_FRAME_MULTIPLE:
                        frame_multiple_reg <= cfg_data[ncse_pkg::FM_W-1:0];
                    default: ;
                endcase
            end
            a_valid_reg <= accept;
            if (accept)
                pos_reg <= pos_next;
            if (push)
            begin
                loaded_reg <= '0;
                null_reg   <= '0;
            end
            else
            begin
                loaded_reg <= loaded_next;
                null_reg   <= null_next;
            end
        end
    end

    // squaring stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sq_i_reg   <= prod_i[ncse_pkg::SQ_W-1:0];
            a_sq_q_reg   <= prod_q[ncse_pkg::SQ_W-1:0];
            a_loaded_reg <= in_loaded;
            a_null_reg   <= in_null;
            a_last_reg   <= is_last;
            a_vl_reg     <= vl_eff;
        end
    end

endmodule

`default_nettype wire

[hdl/ncse_queue.sv]
// two-entry queue of finished frame sums between front and back
`default_nettype none

module ncse_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ncse_pkg::frame_sums_t push_data,
    input  wire logic                  pop,
    output logic                       head_valid,
    output ncse_pkg::frame_sums_t      head,
    output logic [1:0]                 level
);

    ncse_pkg::frame_sums_t mem_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            level_reg, level_next;
    logic                  do_pop;

    assign head_valid = (level_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        level_next = level_reg;
        if (push && !do_pop)
            level_next = level_reg + 2'd1;
        else if (!push && do_pop)
            level_next = level_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[hdl/ncse_back.sv]
// back end: bit-serial division of the frame sums and the result register
`default_nettype none

module ncse_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire ncse_pkg::frame_sums_t head,
    output logic                       pop,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output ncse_pkg::result_t          result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [ncse_pkg::LOADED_W-1:0]   loaded_reg, loaded_next;
    logic [ncse_pkg::NULL_W-1:0]     null_reg, null_next;
    logic [ncse_pkg::VL_W-1:0]       vl_reg, vl_next;
    logic                            neg_reg, neg_next;
    logic                            zero_reg, zero_next;
    logic                            sat_reg, sat_next;
    logic [ncse_pkg::LOADED_W-1:0]   diff_reg, diff_next;
    logic [ncse_pkg::NULL_W-1:0]     rem_reg, rem_next;
    logic [ncse_pkg::NULL_W-1:0]     dvd_reg, dvd_next;
    logic [ncse_pkg::VL_W-1:0]       nrem_reg, nrem_next;
    logic [ncse_pkg::NULL_W-1:0]     ndvd_reg, ndvd_next;
    logic [ncse_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            result_valid_reg, result_valid_next;
    ncse_pkg::result_t               result_reg, result_next;

    logic [ncse_pkg::LOADED_W-1:0]   two_n;
    logic [ncse_pkg::DVD_W-1:0]      dividend, sat_bound;
    logic [ncse_pkg::LOADED_W-1:0]   trial;
    logic [ncse_pkg::VL_W:0]         ntrial;
    logic [ncse_pkg::SNR_W-1:0]      q_up;
    logic                            out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        loaded_next       = loaded_reg;
        null_next         = null_reg;
        vl_next           = vl_reg;
        neg_next          = neg_reg;
        zero_next         = zero_reg;
        sat_next          = sat_reg;
        diff_next         = diff_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        nrem_next         = nrem_reg;
        ndvd_next         = ndvd_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        pop               = 1'b0;

        two_n     = {null_reg, 1'b0};
        dividend  = {diff_reg, {ncse_pkg::FRAC_SHIFT{1'b0}}};
        sat_bound = ncse_pkg::DVD_W'(null_reg) << ncse_pkg::SAT_SHIFT;
        trial     = {rem_reg, dvd_reg[ncse_pkg::NULL_W-1]};
        ntrial    = {nrem_reg, ndvd_reg[ncse_pkg::NULL_W-1]};
        q_up      = dvd_reg[ncse_pkg::SNR_W-1:0] + ncse_pkg::SNR_W'(rem_reg != '0);

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    loaded_next = head.loaded_sum;
                    null_next   = head.null_sum;
                    vl_next     = head.vector_length;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // sign and magnitude of loaded - 2*null
                zero_next = (null_reg == '0);
                neg_next  = (loaded_reg < two_n);
                diff_next = (loaded_reg < two_n) ? (two_n - loaded_reg)
                                                 : (loaded_reg - two_n);
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                // quotient of at least 2^31 saturates
                sat_next  = !neg_reg && (ncse_pkg::DVD_W'(diff_reg) >= sat_bound);
                rem_next  = ncse_pkg::NULL_W'(dividend[ncse_pkg::DVD_W-1:ncse_pkg::NULL_W]);
                dvd_next  = dividend[ncse_pkg::NULL_W-1:0];
                nrem_next = '0;
                ndvd_next = null_reg;
                cnt_next  = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // one restoring step of each division, quotient bits shift in below
                if (trial >= ncse_pkg::LOADED_W'(null_reg))
                begin
                    rem_next = ncse_pkg::NULL_W'(trial - ncse_pkg::LOADED_W'(null_reg));
                    dvd_next = {dvd_reg[ncse_pkg::NULL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[ncse_pkg::NULL_W-1:0];
                    dvd_next = {dvd_reg[ncse_pkg::NULL_W-2:0], 1'b0};
                end
                if (ntrial >= {1'b0, vl_reg})
                begin
                    nrem_next = ncse_pkg::VL_W'(ntrial - {1'b0, vl_reg});
                    ndvd_next = {ndvd_reg[ncse_pkg::NULL_W-2:0], 1'b1};
                end
                else
                begin
                    nrem_next = ntrial[ncse_pkg::VL_W-1:0];
                    ndvd_next = {ndvd_reg[ncse_pkg::NULL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + ncse_pkg::CNT_W'(1);
                if (cnt_reg == ncse_pkg::CNT_W'(ncse_pkg::DIV_STEPS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (zero_reg)
                    begin
                        result_next.snr_estimate    = ncse_pkg::SNR_MAX;
                        result_next.noise_power     = '0;
                        result_next.null_power_zero = 1'b1;
                    end
                    else
                    begin
                        if (sat_reg)
                            result_next.snr_estimate = ncse_pkg::SNR_MAX;
                        else if (neg_reg)
                            result_next.snr_estimate = -$signed(q_up);
                        else
                            result_next.snr_estimate = $signed(dvd_reg[ncse_pkg::SNR_W-1:0]);
                        result_next.noise_power     = ndvd_reg[ncse_pkg::NOISE_W-1:0];
                        result_next.null_power_zero = 1'b0;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        loaded_reg <= loaded_next;
        null_reg   <= null_next;
        vl_reg     <= vl_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        sat_reg    <= sat_next;
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        nrem_reg   <= nrem_next;
        ndvd_reg   <= ndvd_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

[hdl/null_carrier_snr_estimator.sv]
// top level of the null-carrier snr estimator
//
// sample channel: one complex sample (i, q, signed q1.15) per transaction on
//   sample_valid / sample_ready; frames are vector_length * frame_multiple
//   samples, the first 2*vector_length form the loaded window, the next
//   vector_length the null window, the rest are ignored
// result channel: one transaction per frame on result_valid / result_ready,
//   carrying snr_estimate (q16.16), noise_power (q2.30) and null_power_zero
// configuration: cfg_write strobes cfg_data into register cfg_index
//   (0 vector_length, 1 frame_multiple) at once, with no handshake
// throughput: one sample per cycle inside a frame while sample_ready is high;
//   each frame end costs the back end a 42-step shift-subtract divider pair
//   plus set-up; the two-entry frame queue absorbs frames that end faster
//   than the back end takes them until it fills, then sample_ready drops
// result path: squaring stage, frame queue, then the back end's check, set-up,
//   divider steps and finish states ahead of result_valid
// reset: configuration returns to 64 and 4, the frame restarts at sample 0,
//   sums, queue and result register are emptied
// receiver stall: the result register holds its transaction; the back end
//   finishes the next division and waits, the queue then fills and the
//   sample channel stalls only when no slot is left
`default_nettype none

module null_carrier_snr_estimator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [ncse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ncse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            sample_valid,
    output logic                                 sample_ready,
    input  wire ncse_pkg::sample_t               sample,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output ncse_pkg::result_t                    result
);

    logic                  push;
    ncse_pkg::frame_sums_t push_data;
    logic                  pop;
    logic                  head_valid;
    ncse_pkg::frame_sums_t head;
    logic [1:0]            queue_level;

    // accumulates window powers and hands a frame's sums over at its end
    ncse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .queue_level  (queue_level),
        .push         (push),
        .push_data    (push_data)
    );

    // decouples the streaming front from the slow divider
    ncse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .level      (queue_level)
    );

    // snr and noise divisions, result register
    ncse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

[hdl/ncse_checker.sv]
// port-level checks of the null-carrier snr estimator and their binding
`default_nettype none

module ncse_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              result_valid,
    input  wire logic              result_ready,
    input  wire ncse_pkg::result_t result
);

    // a stalled result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // zero null power forces the saturated estimate and zero noise
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.null_power_zero |->
            result.snr_estimate == ncse_pkg::SNR_MAX && result.noise_power == '0)
        else $error("zero null power with wrong payload");

    // floor of -1 in q16.16 is the lowest estimate
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.snr_estimate >= -32'sd65536)
        else $error("snr estimate below minimum");

endmodule

bind null_carrier_snr_estimator ncse_checker u_ncse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[dv/snr_frame_checker.sv]
// result prediction and comparison for the null-carrier snr estimator
`default_nettype none

module snr_frame_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [ncse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ncse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            sample_valid,
    input  wire logic                            sample_ready,
    input  wire ncse_pkg::sample_t               sample,
    input  wire logic                            result_valid,
    input  wire logic                            result_ready,
    input  wire ncse_pkg::result_t               result,
    output int                                   mismatches,
    output int                                   outstanding
);

    import ncse_pkg::*;

    logic [VL_W-1:0] vec_len_reg;
    logic [FM_W-1:0] frame_mult_reg;
    logic [63:0]     frame_pos;
    logic [63:0]     loaded_acc;
    logic [63:0]     null_acc;
    result_t         expected_estimates[$];

    // snr and mean noise power of one finished frame
    function automatic result_t frame_estimate(input logic [63:0] loaded,
                                               input logic [63:0] nulls,
                                               input logic [63:0] vl);
        result_t     r;
        logic [63:0] q;
        r.null_power_zero = 1'b0;
        r.noise_power     = '0;
        r.snr_estimate    = SNR_MAX;
        if (nulls == 0)
        begin
            r.null_power_zero = 1'b1;
        end
        else
        begin
            if (loaded >= 2 * nulls)
            begin
                q = ((loaded - 2 * nulls) << FRAC_SHIFT) / nulls;
                if (q <= 64'h7FFF_FFFF)
                    r.snr_estimate = q[31:0];
            end
            else
            begin
                // floor of a negative quotient
                q = (((2 * nulls - loaded) << FRAC_SHIFT) + nulls - 1) / nulls;
                r.snr_estimate = -q[31:0];
            end
            r.noise_power = 32'(nulls / vl);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [63:0] vl;
        logic [63:0] flen;
        logic [63:0] mag;
        longint      si;
        longint      sq;
        result_t     want;
        if (!rst_n)
        begin
            vec_len_reg    = VL_RESET;
            frame_mult_reg = FM_RESET;
            frame_pos      = '0;
            loaded_acc     = '0;
            null_acc       = '0;
            expected_estimates.delete();
            mismatches     = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (result.snr_estimate !== want.snr_estimate)
                    begin
                        $error("snr_estimate: expected %0d, got %0d",
                               want.snr_estimate, result.snr_estimate);
                        mismatches++;
                    end
                    if (result.noise_power !== want.noise_power)
                    begin
                        $error("noise_power: expected %0d, got %0d",
                               want.noise_power, result.noise_power);
                        mismatches++;
                    end
                    if (result.null_power_zero !== want.null_power_zero)
                    begin
                        $error("null_power_zero: expected %0d, got %0d",
                               want.null_power_zero, result.null_power_zero);
                        mismatches++;
                    end
                end
            end

            if (sample_valid && sample_ready)
            begin
                vl = (vec_len_reg == 0) ? 64'd1 :
                     (vec_len_reg > MAX_VECTOR_LENGTH) ? 64'(MAX_VECTOR_LENGTH) :
                     64'(vec_len_reg);
                flen = (frame_mult_reg < 3) ? 64'd3 :
                       (frame_mult_reg > MAX_FRAME_MULTIPLE) ? 64'(MAX_FRAME_MULTIPLE) :
                       64'(frame_mult_reg);
                flen = flen * vl;
                si   = $signed(sample.sample_i);
                sq   = $signed(sample.sample_q);
                mag  = 64'(si * si + sq * sq);
                if (frame_pos < 2 * vl)
                    loaded_acc = loaded_acc + mag;
                else if (frame_pos < 3 * vl)
                    null_acc = null_acc + mag;
                if (frame_pos + 1 < flen)
                begin
                    frame_pos = frame_pos + 1;
                end
                else
                begin
                    expected_estimates.push_back(frame_estimate(loaded_acc, null_acc, vl));
                    frame_pos  = '0;
                    loaded_acc = '0;
                    null_acc   = '0;
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_VECTOR_LENGTH:  vec_len_reg    = cfg_data[VL_W-1:0];
                    CFG_FRAME_MULTIPLE: frame_mult_reg = cfg_data[FM_W-1:0];
                    default: ;
                endcase
            end

            outstanding <= expected_estimates.size();
        end
    end

endmodule

`default_nettype wire

[dv/testbench.sv]
// stimulus, watchdog and verdict for the null-carrier snr estimator
`default_nettype none

module testbench;

    import ncse_pkg::*;

    localparam int IDLE_PERCENT   = 37;
    localparam int ITEM_GOAL      = 1800;
    localparam int FRAME_GOAL     = 48;
    localparam int SETTLE_CYCLES  = 64;    // idle time after the last result before the next setting
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PEAK_PHASE     = 6;
    localparam int PEAK_END_POS   = 780;   // past loaded and null windows of the peak setting

    // how the samples of one frame are shaped, window by window
    typedef enum int {
        CONTENT_RANDOM,
        CONTENT_NULL_ZERO,
        CONTENT_NULL_TINY,
        CONTENT_LOADED_ZERO,
        CONTENT_FULL_SCALE,
        CONTENT_PEAK,
        CONTENT_SILENT,
        CONTENT_SMALL
    } content_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_ready;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;

    int mismatches;
    int outstanding;

    int       quiet_cycles = 0;
    int       frames_seen  = 0;
    int       items_sent   = 0;
    // mirror of the frame position, only used to shape the stimulus
    int       eff_vl       = int'(VL_RESET);
    int       eff_fm       = int'(FM_RESET);
    int       frame_pos    = 0;
    content_t content      = CONTENT_RANDOM;
    logic     steady       = 1'b0;

    // short frames (vector_length 1, frame_multiple 3): two loaded samples, one null
    logic [31:0] directed_frames [21] = '{
        // full-scale loaded, null of one lsb: estimate saturates
        32'h8000_8000, 32'h7FFF_7FFF, 32'h0001_0000,
        // silent loaded window: estimate at its minimum
        32'h0000_0000, 32'h0000_0000, 32'h0005_FFFD,
        // silent null window
        32'h0064_0064, 32'h0000_0000, 32'h0000_0000,
        // all silent, zero flag with zero loaded sum
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        // largest magnitudes, noise power at its top
        32'h8000_0000, 32'h0000_8000, 32'h8000_8000,
        // loaded exactly twice null: estimate zero
        32'h0001_0001, 32'h0001_0001, 32'h0001_0001,
        // mixed extremes
        32'h7FFF_8000, 32'h8001_7FFF, 32'hFFFF_0000
    };

    null_carrier_snr_estimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    snr_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: stalls at random unless the current phase runs without idling
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // watchdog on cycles with no transaction on any port, plus a frame count
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            frames_seen <= frames_seen + 1;
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic content_t random_content();
        case ($urandom_range(0, 11))
            4:       return CONTENT_NULL_ZERO;
            5, 6:    return CONTENT_NULL_TINY;
            7:       return CONTENT_LOADED_ZERO;
            8:       return CONTENT_FULL_SCALE;
            9:       return CONTENT_SILENT;
            10, 11:  return CONTENT_SMALL;
            default: return CONTENT_RANDOM;
        endcase
    endfunction

    // next sample, shaped by the window it lands in
    function automatic sample_t shaped_sample();
        sample_t s;
        logic    in_loaded;
        logic    in_null;
        in_loaded  = frame_pos < 2 * eff_vl;
        in_null    = !in_loaded && frame_pos < 3 * eff_vl;
        s.sample_i = 16'($urandom);
        s.sample_q = 16'($urandom);
        case (content)
            CONTENT_NULL_ZERO:
                if (in_null)
                    s = '0;
            CONTENT_NULL_TINY:
                if (in_null)
                begin
                    // a few lsbs of null power against a busy loaded window
                    s.sample_i = 16'($urandom_range(0, 2)) - 16'd1;
                    s.sample_q = 16'($urandom_range(0, 2)) - 16'd1;
                end
            CONTENT_LOADED_ZERO:
                if (in_loaded)
                    s = '0;
            CONTENT_FULL_SCALE:
            begin
                s.sample_i = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                s.sample_q = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            CONTENT_PEAK:
                s = {16'h8000, 16'h8000};
            CONTENT_SILENT:
                s = '0;
            CONTENT_SMALL:
            begin
                s.sample_i = 16'($urandom_range(0, 16)) - 16'd8;
                s.sample_q = 16'($urandom_range(0, 16)) - 16'd8;
            end
            default: ;
        endcase
        return s;
    endfunction

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_sample(input sample_t s);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        frame_pos = (frame_pos + 1 >= eff_vl * eff_fm) ? 0 : frame_pos + 1;
    endtask

    // sender pauses until every result is in, then lets the back end settle
    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers, vector_length first and then frame_multiple, written while the block is idle
    task automatic configure(input logic [CFG_DATA_W-1:0] vl_word,
                             input logic [CFG_DATA_W-1:0] fm_word);
        cfg_write <= 1'b1;
        cfg_index <= CFG_VECTOR_LENGTH;
        cfg_data  <= vl_word;
        @(posedge clk);
        cfg_index <= CFG_FRAME_MULTIPLE;
        cfg_data  <= fm_word;
        @(posedge clk);
        cfg_write <= 1'b0;
        eff_vl = (vl_word == 0) ? 1 :
                 (vl_word > MAX_VECTOR_LENGTH) ? MAX_VECTOR_LENGTH : int'(vl_word);
        eff_fm = (fm_word[FM_W-1:0] < 3) ? 3 :
                 (fm_word[FM_W-1:0] > MAX_FRAME_MULTIPLE) ? MAX_FRAME_MULTIPLE :
                 int'(fm_word[FM_W-1:0]);
    endtask

    // a run of samples under one setting; may stop mid-frame unless told not to
    task automatic run_phase(input int count, input logic peak, input logic to_boundary);
        int sent;
        sent = 0;
        if (peak)
            content = CONTENT_PEAK;
        while (sent < count || (to_boundary && frame_pos != 0))
        begin
            if (frame_pos == 0 && !peak)
                content = random_content();
            send_sample(shaped_sample());
            sent++;
        end
        items_sent += sent;
    endtask

    initial
    begin
        int                    phase;
        logic [CFG_DATA_W-1:0] vl_word;
        logic [CFG_DATA_W-1:0] fm_word;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_VECTOR_LENGTH;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // one whole frame at the reset settings
        run_phase(int'(VL_RESET) * int'(FM_RESET), 1'b0, 1'b1);

        // directed frames at the smallest sizes
        drain();
        configure(11'd1, 11'd3);
        foreach (directed_frames[k])
            send_sample(directed_frames[k]);

        // random phases; each boundary drains the block before reconfiguring, and
        // most phases end mid-frame so a new setting lands inside a running frame
        phase = 0;
        while (items_sent < ITEM_GOAL || frames_seen < FRAME_GOAL)
        begin
            drain();
            if (phase == PEAK_PHASE)
            begin
                // long frame, full-scale samples, no idling on either side;
                // a later, shorter setting ends this frame
                configure(11'h100, 11'h7FF);
                steady <= 1'b1;
                run_phase(PEAK_END_POS - frame_pos, 1'b1, 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       vl_word = '0;
                    1:       vl_word = CFG_DATA_W'($urandom_range(7, 40));
                    2:       vl_word = VL_RESET;
                    // above the largest window; kept off the phase that runs to a boundary
                    3:       vl_word = (phase == PEAK_PHASE - 1) ? VL_RESET :
                                       CFG_DATA_W'($urandom_range(MAX_VECTOR_LENGTH + 1,
                                                                  2047));
                    default: vl_word = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                // upper bits are junk the register must drop
                fm_word = CFG_DATA_W'($urandom);
                configure(vl_word, fm_word);
                steady <= ($urandom_range(0, 4) == 0);
                // the phase before the peak stops on a frame boundary
                run_phase($urandom_range(10, 150), 1'b0, phase == PEAK_PHASE - 1);
            end
            phase++;
        end

        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hdl/ncse_pkg.sv
hdl/ncse_front.sv
hdl/ncse_queue.sv
hdl/ncse_back.sv
hdl/null_carrier_snr_estimator.sv
hdl/ncse_checker.sv
dv/snr_frame_checker.sv
dv/testbench.sv
